/* rtl/core/rvt_pkg.sv */
// Shared constants, types and sequencer states for the ray voxel traversal unit.
`default_nettype none
package rvt_pkg;
  localparam int COORD_W    = 20;
  localparam int DX_W       = 21;
  localparam int VOX_W      = 6;
  localparam int LEN_W      = 17;
  localparam int GRID_W     = 5;
  localparam int AXCNT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int MAX_GRID   = 16;
  localparam int AXCNT_RST  = 3;
  localparam int FRAC_BITS  = 12;
  localparam int GUARD_BITS = 8;
  localparam int NAXES      = 3;
  localparam int MAX_OUT    = 64;
  localparam int CNT_W      = 6;
  localparam int TOT_W      = 21;
  localparam int SUM_W      = 43;
  localparam int MUL_A_W    = 30;
  localparam int MUL_B_W    = 22;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int WIDE_W     = 54;
  localparam int DVSR_W     = TOT_W + GUARD_BITS + FRAC_BITS;
  localparam int DIV_STEPS  = WIDE_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int TRAV_W     = 30;
  localparam int RND_W      = TRAV_W - GUARD_BITS + 1;
  localparam int UX_W       = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X     = 2'd0,
    CFG_GRID_Y     = 2'd1,
    CFG_GRID_Z     = 2'd2,
    CFG_AXIS_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_SQ    = 22'h000002,
    ST_SQACC = 22'h000004,
    ST_ROOT  = 22'h000008,
    ST_EN_M  = 22'h000010,
    ST_EN_D  = 22'h000020,
    ST_EN_W  = 22'h000040,
    ST_EX_M  = 22'h000080,
    ST_EX_D  = 22'h000100,
    ST_EX_W  = 22'h000200,
    ST_CHK   = 22'h000400,
    ST_VX_M1 = 22'h000800,
    ST_VX_M2 = 22'h001000,
    ST_VX_D  = 22'h002000,
    ST_VX_W  = 22'h004000,
    ST_CS_D  = 22'h008000,
    ST_CS_W  = 22'h010000,
    ST_NC_M  = 22'h020000,
    ST_NC_D  = 22'h040000,
    ST_NC_W  = 22'h080000,
    ST_WALK  = 22'h100000,
    ST_OUT   = 22'h200000
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] dividend;
    logic [DVSR_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] quotient;
    logic                     exact;
  } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/rvt_cfg_if.sv */
// Configuration write channel.
`default_nettype none
interface rvt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rvt_pkg::CFG_IDX_W-1:0]   index;
  logic [rvt_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/rvt_ray_if.sv */
// Ray request channel.
`default_nettype none
interface rvt_ray_if;
  logic                                valid;
  logic                                ready;
  logic signed [rvt_pkg::COORD_W-1:0]  start_x;
  logic signed [rvt_pkg::COORD_W-1:0]  start_y;
  logic signed [rvt_pkg::COORD_W-1:0]  start_z;
  logic signed [rvt_pkg::COORD_W-1:0]  end_x;
  logic signed [rvt_pkg::COORD_W-1:0]  end_y;
  logic signed [rvt_pkg::COORD_W-1:0]  end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/rvt_seg_if.sv */
// Voxel segment result channel.
`default_nettype none
interface rvt_seg_if;
  logic                              valid;
  logic                              ready;
  logic signed [rvt_pkg::VOX_W-1:0]  voxel_x;
  logic signed [rvt_pkg::VOX_W-1:0]  voxel_y;
  logic signed [rvt_pkg::VOX_W-1:0]  voxel_z;
  logic [rvt_pkg::LEN_W-1:0]         segment_length;
  logic                              hit;
  logic                              last;
  modport source (output valid, voxel_x, voxel_y, voxel_z, segment_length, hit, last,
                  input ready);
  modport sink (input valid, voxel_x, voxel_y, voxel_z, segment_length, hit, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/rvt_div.sv */
// Shared signed-by-positive floor divider, one quotient bit per cycle.
`default_nettype none
module rvt_div (
  input  logic              clk,
  input  logic              rst,
  input  rvt_pkg::div_req_t req,
  output rvt_pkg::div_rsp_t rsp
);
  logic                              busy;
  logic                              fin;
  logic                              neg;
  logic [rvt_pkg::DCNT_W-1:0]        cnt;
  logic [rvt_pkg::WIDE_W-1:0]        mag;
  logic [rvt_pkg::WIDE_W-1:0]        qinc;
  logic [rvt_pkg::DVSR_W-1:0]        rem;
  logic [rvt_pkg::DVSR_W-1:0]        dvsr;
  logic [rvt_pkg::DVSR_W:0]          trial;
  logic                              fits;

  assign trial = {rem, mag[rvt_pkg::WIDE_W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign qinc  = mag + rvt_pkg::WIDE_W'(rem != '0);

  assign rsp.done     = fin;
  assign rsp.exact    = (rem == '0);
  assign rsp.quotient = neg ? -signed'(qinc) : signed'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + rvt_pkg::DCNT_W'(1);
        if (cnt == rvt_pkg::DCNT_W'(rvt_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg  <= req.dividend[rvt_pkg::WIDE_W-1];
      mag  <= req.dividend[rvt_pkg::WIDE_W-1] ? rvt_pkg::WIDE_W'(-req.dividend)
                                               : rvt_pkg::WIDE_W'(req.dividend);
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      mag <= {mag[rvt_pkg::WIDE_W-2:0], fits};
      rem <= fits ? rvt_pkg::DVSR_W'(trial - {1'b0, dvsr}) : trial[rvt_pkg::DVSR_W-1:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ray_voxel_traversal_unit.sv */
// Ray voxel traversal unit: clips a ray to the grid and walks the voxels it crosses.
// Usage:
//   cfg: write channel, index 0..2 sets grid size x/y/z, index 3 sets axis count
//        (2 = planar, else volume). Always ready; write only while idle.
//   ray: one request is a ray (start and end point, signed Q8.12). ray.ready is
//        high only while the unit is idle; one ray is traced at a time.
//   seg: one result per crossed voxel (indices, Q5.12 length), last flagged;
//        a missed or zero-length ray gives a single result with hit=0.
// Sequence: squaring and bit-serial square root, then a series of divisions
//   on the shared one-bit-per-cycle divider: two per moving axis for
//   clipping, three per moving axis for the entry voxel and crossing
//   distances, one per still axis.
// Results: at most 64 per ray.
// Reset: grid sizes return to 16, axis count to 3, unit idle.
// Stall: a result holds in the output register until taken; tracing waits.
`default_nettype none
module ray_voxel_traversal_unit (
  input  logic    clk,
  input  logic    rst,
  rvt_cfg_if.sink cfg,
  rvt_ray_if.sink ray,
  rvt_seg_if.source seg
);
  rvt_pkg::state_t state;

  logic [rvt_pkg::GRID_W-1:0]          grid_x, grid_y, grid_z;
  logic [rvt_pkg::AXCNT_W-1:0]         axis_count;
  logic                                three_d;
  logic [1:0]                          ax;
  logic signed [rvt_pkg::COORD_W-1:0]  from_r [rvt_pkg::NAXES];
  logic signed [rvt_pkg::DX_W-1:0]     dx_r   [rvt_pkg::NAXES];
  logic [rvt_pkg::SUM_W-1:0]           sum, rr, rb, rt, rr_next, sum_next;
  logic                                rfit;
  logic [rvt_pkg::TOT_W-1:0]           tot;
  logic signed [rvt_pkg::WIDE_W-1:0]   lmin, lmax, acc;
  logic signed [rvt_pkg::MUL_P_W-1:0]  mul_p;
  logic signed [rvt_pkg::UX_W-1:0]     ux, q8;
  logic [rvt_pkg::VOX_W-1:0]           cur [rvt_pkg::NAXES];
  logic signed [rvt_pkg::WIDE_W-1:0]   nc  [rvt_pkg::NAXES];
  logic signed [rvt_pkg::WIDE_W-1:0]   cs  [rvt_pkg::NAXES];
  logic [rvt_pkg::TRAV_W-1:0]          trav;
  logic [rvt_pkg::CNT_W-1:0]           cnt;

  logic [rvt_pkg::VOX_W-1:0]           o_vx, o_vy, o_vz;
  logic [rvt_pkg::LEN_W-1:0]           o_len;
  logic                                o_hit, o_last;

  logic signed [rvt_pkg::MUL_A_W-1:0]  from_a, n2f_a, ux_a, mul_a;
  logic signed [rvt_pkg::MUL_B_W-1:0]  dx_b, tot_b, mul_b;
  logic [rvt_pkg::DX_W-1:0]            adx;
  logic                                dpos, dneg, ax_last;
  logic [rvt_pkg::GRID_W-1:0]          gc;

  logic [1:0]                          sel;
  logic                                sel_ok, at_end, w_last;
  logic signed [rvt_pkg::WIDE_W-1:0]   trav_s;
  logic [rvt_pkg::TRAV_W-1:0]          w_end;
  logic [rvt_pkg::RND_W-1:0]           len_raw;
  logic [rvt_pkg::LEN_W-1:0]           len_sat;

  rvt_pkg::div_req_t                   div_req;
  rvt_pkg::div_rsp_t                   div_rsp;

  function automatic logic [rvt_pkg::GRID_W-1:0] gclamp(input logic [rvt_pkg::GRID_W-1:0] g);
    if (g == '0) return rvt_pkg::GRID_W'(1);
    if (g > rvt_pkg::GRID_W'(rvt_pkg::MAX_GRID)) return rvt_pkg::GRID_W'(rvt_pkg::MAX_GRID);
    return g;
  endfunction

  function automatic logic [rvt_pkg::RND_W-1:0] rnd_out(input logic [rvt_pkg::TRAV_W-1:0] x);
    logic [rvt_pkg::TRAV_W:0] s;
    s = {1'b0, x} + (rvt_pkg::TRAV_W + 1)'(1 << (rvt_pkg::GUARD_BITS - 1));
    return s[rvt_pkg::TRAV_W:rvt_pkg::GUARD_BITS];
  endfunction

  rvt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg.ready = 1'b1;
  assign ray.ready = (state == rvt_pkg::ST_IDLE);

  assign seg.valid          = (state == rvt_pkg::ST_OUT);
  assign seg.voxel_x        = o_vx;
  assign seg.voxel_y        = o_vy;
  assign seg.voxel_z        = o_vz;
  assign seg.segment_length = o_len;
  assign seg.hit            = o_hit;
  assign seg.last           = o_last;

  // per-axis operands
  always_comb begin
    case (ax)
      2'd0:    gc = gclamp(grid_x);
      2'd1:    gc = gclamp(grid_y);
      default: gc = gclamp(grid_z);
    endcase
  end

  assign from_a  = rvt_pkg::MUL_A_W'(from_r[ax]);
  assign n2f_a   = rvt_pkg::MUL_A_W'({gc, {rvt_pkg::FRAC_BITS{1'b0}}});
  assign ux_a    = rvt_pkg::MUL_A_W'(ux) <<< rvt_pkg::FRAC_BITS;
  assign dx_b    = rvt_pkg::MUL_B_W'(dx_r[ax]);
  assign tot_b   = signed'({1'b0, tot});
  assign dneg    = dx_r[ax][rvt_pkg::DX_W-1];
  assign dpos    = !dneg && (dx_r[ax] != '0);
  assign adx     = dneg ? rvt_pkg::DX_W'(-dx_r[ax]) : rvt_pkg::DX_W'(dx_r[ax]);
  assign ax_last = (ax == (three_d ? 2'd2 : 2'd1));
  assign q8      = div_rsp.quotient[rvt_pkg::UX_W-1:0];

  // square root step
  assign rt       = rr + rb;
  assign rfit     = sum >= rt;
  assign rr_next  = rfit ? (rr >> 1) + rb : rr >> 1;
  assign sum_next = rfit ? sum - rt : sum;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      rvt_pkg::ST_SQ: begin
        mul_a = rvt_pkg::MUL_A_W'(dx_r[ax]);
        mul_b = dx_b;
      end
      rvt_pkg::ST_EN_M: begin
        mul_a = dpos ? -from_a : from_a - n2f_a;
        mul_b = tot_b;
      end
      rvt_pkg::ST_EX_M: begin
        mul_a = dpos ? n2f_a - from_a : from_a;
        mul_b = tot_b;
      end
      rvt_pkg::ST_VX_M1: begin
        mul_a = from_a;
        mul_b = tot_b;
      end
      rvt_pkg::ST_VX_M2: begin
        mul_a = rvt_pkg::MUL_A_W'(lmin);
        mul_b = dx_b;
      end
      rvt_pkg::ST_NC_M: begin
        mul_a = dpos ? ux_a - from_a : from_a - ux_a;
        mul_b = tot_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // divider request
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = rvt_pkg::WIDE_W'(mul_p) <<< rvt_pkg::GUARD_BITS;
    div_req.divisor  = rvt_pkg::DVSR_W'(adx);
    case (state)
      rvt_pkg::ST_EN_D, rvt_pkg::ST_EX_D, rvt_pkg::ST_NC_D: div_req.start = 1'b1;
      rvt_pkg::ST_VX_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc + rvt_pkg::WIDE_W'(mul_p);
        div_req.divisor  = {tot, {(rvt_pkg::GUARD_BITS + rvt_pkg::FRAC_BITS){1'b0}}};
      end
      rvt_pkg::ST_CS_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = rvt_pkg::WIDE_W'(
          {tot, {(rvt_pkg::GUARD_BITS + rvt_pkg::FRAC_BITS){1'b0}}});
      end
      default: ;
    endcase
  end

  // next crossing search
  always_comb begin
    sel_ok = 1'b0;
    sel    = 2'd0;
    for (int i = 0; i < rvt_pkg::NAXES; i++) begin
      if ((i < 2 || three_d) && dx_r[i] != '0 && (!sel_ok || nc[i] < nc[sel])) begin
        sel_ok = 1'b1;
        sel    = 2'(i);
      end
    end
  end

  assign trav_s  = signed'(rvt_pkg::WIDE_W'(trav));
  assign at_end  = !sel_ok || (nc[sel] >= lmax);
  assign w_last  = at_end || (cnt == rvt_pkg::CNT_W'(rvt_pkg::MAX_OUT - 1));
  assign w_end   = at_end ? lmax[rvt_pkg::TRAV_W-1:0]
                 : (nc[sel] > trav_s ? nc[sel][rvt_pkg::TRAV_W-1:0] : trav);
  assign len_raw = rnd_out(w_end) - rnd_out(trav);
  assign len_sat = (len_raw > rvt_pkg::RND_W'(rvt_pkg::LEN_MAX)) ? rvt_pkg::LEN_MAX
                                                               : len_raw[rvt_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rvt_pkg::ST_IDLE;
      grid_x     <= rvt_pkg::GRID_W'(rvt_pkg::MAX_GRID);
      grid_y     <= rvt_pkg::GRID_W'(rvt_pkg::MAX_GRID);
      grid_z     <= rvt_pkg::GRID_W'(rvt_pkg::MAX_GRID);
      axis_count <= rvt_pkg::AXCNT_W'(rvt_pkg::AXCNT_RST);
      ax         <= 2'd0;
      cnt        <= '0;
    end else begin
      if (cfg.valid) begin
        case (rvt_pkg::cfg_idx_t'(cfg.index))
          rvt_pkg::CFG_GRID_X:     grid_x <= cfg.data;
          rvt_pkg::CFG_GRID_Y:     grid_y <= cfg.data;
          rvt_pkg::CFG_GRID_Z:     grid_z <= cfg.data;
          rvt_pkg::CFG_AXIS_COUNT: axis_count <= cfg.data[rvt_pkg::AXCNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        rvt_pkg::ST_IDLE: begin
          if (ray.valid) begin
            three_d   <= (axis_count != 2'd2);
            from_r[0] <= ray.start_x;
            from_r[1] <= ray.start_y;
            dx_r[0]   <= rvt_pkg::DX_W'(ray.end_x) - rvt_pkg::DX_W'(ray.start_x);
            dx_r[1]   <= rvt_pkg::DX_W'(ray.end_y) - rvt_pkg::DX_W'(ray.start_y);
            if (axis_count != 2'd2) begin
              from_r[2] <= ray.start_z;
              dx_r[2]   <= rvt_pkg::DX_W'(ray.end_z) - rvt_pkg::DX_W'(ray.start_z);
            end else begin
              from_r[2] <= '0;
              dx_r[2]   <= '0;
            end
            for (int i = 0; i < rvt_pkg::NAXES; i++) cur[i] <= '0;
            sum   <= '0;
            ax    <= 2'd0;
            state <= rvt_pkg::ST_SQ;
          end
        end
        rvt_pkg::ST_SQ: state <= rvt_pkg::ST_SQACC;
        rvt_pkg::ST_SQACC: begin
          sum <= sum + rvt_pkg::SUM_W'(mul_p);
          if (ax_last) begin
            rr    <= '0;
            rb    <= rvt_pkg::SUM_W'(1) << (rvt_pkg::SUM_W - 1);
            state <= rvt_pkg::ST_ROOT;
          end else begin
            ax    <= ax + 2'd1;
            state <= rvt_pkg::ST_SQ;
          end
        end
        rvt_pkg::ST_ROOT: begin
          sum <= sum_next;
          rr  <= rr_next;
          rb  <= rb >> 2;
          if (rb[0]) begin
            tot <= rvt_pkg::TOT_W'(rr_next);
            if (rr_next == '0) begin
              o_vx <= '0; o_vy <= '0; o_vz <= '0; o_len <= '0;
              o_hit <= 1'b0; o_last <= 1'b1;
              state <= rvt_pkg::ST_OUT;
            end else begin
              lmin  <= '0;
              lmax  <= rvt_pkg::WIDE_W'({rr_next[rvt_pkg::TOT_W-1:0],
                                         {rvt_pkg::GUARD_BITS{1'b0}}});
              ax    <= 2'd0;
              state <= rvt_pkg::ST_EN_M;
            end
          end
        end
        rvt_pkg::ST_EN_M: begin
          if (dx_r[ax] == '0) begin
            if (from_a <= 0 || from_a >= n2f_a) begin
              o_vx <= '0; o_vy <= '0; o_vz <= '0; o_len <= '0;
              o_hit <= 1'b0; o_last <= 1'b1;
              state <= rvt_pkg::ST_OUT;
            end else if (ax_last) begin
              state <= rvt_pkg::ST_CHK;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            state <= rvt_pkg::ST_EN_D;
          end
        end
        rvt_pkg::ST_EN_D: state <= rvt_pkg::ST_EN_W;
        rvt_pkg::ST_EN_W: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > lmin) lmin <= div_rsp.quotient;
            state <= rvt_pkg::ST_EX_M;
          end
        end
        rvt_pkg::ST_EX_M: state <= rvt_pkg::ST_EX_D;
        rvt_pkg::ST_EX_D: state <= rvt_pkg::ST_EX_W;
        rvt_pkg::ST_EX_W: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient < lmax) lmax <= div_rsp.quotient;
            if (ax_last) begin
              state <= rvt_pkg::ST_CHK;
            end else begin
              ax    <= ax + 2'd1;
              state <= rvt_pkg::ST_EN_M;
            end
          end
        end
        rvt_pkg::ST_CHK: begin
          if (lmin >= lmax) begin
            o_vx <= '0; o_vy <= '0; o_vz <= '0; o_len <= '0;
            o_hit <= 1'b0; o_last <= 1'b1;
            state <= rvt_pkg::ST_OUT;
          end else begin
            ax    <= 2'd0;
            state <= rvt_pkg::ST_VX_M1;
          end
        end
        rvt_pkg::ST_VX_M1: state <= rvt_pkg::ST_VX_M2;
        rvt_pkg::ST_VX_M2: begin
          acc   <= rvt_pkg::WIDE_W'(mul_p) <<< rvt_pkg::GUARD_BITS;
          state <= rvt_pkg::ST_VX_D;
        end
        rvt_pkg::ST_VX_D: state <= rvt_pkg::ST_VX_W;
        rvt_pkg::ST_VX_W: begin
          if (div_rsp.done) begin
            cur[ax] <= rvt_pkg::VOX_W'((div_rsp.exact && dpos) ? q8 - 8'sd1 : q8);
            ux      <= (dpos && !div_rsp.exact) ? q8 + 8'sd1 : q8;
            if (dx_r[ax] == '0) begin
              cs[ax] <= '0;
              nc[ax] <= lmax + lmax;
              if (ax_last) begin
                trav  <= lmin[rvt_pkg::TRAV_W-1:0];
                cnt   <= '0;
                state <= rvt_pkg::ST_WALK;
              end else begin
                ax    <= ax + 2'd1;
                state <= rvt_pkg::ST_VX_M1;
              end
            end else begin
              state <= rvt_pkg::ST_CS_D;
            end
          end
        end
        rvt_pkg::ST_CS_D: state <= rvt_pkg::ST_CS_W;
        rvt_pkg::ST_CS_W: begin
          if (div_rsp.done) begin
            cs[ax] <= div_rsp.quotient;
            state  <= rvt_pkg::ST_NC_M;
          end
        end
        rvt_pkg::ST_NC_M: state <= rvt_pkg::ST_NC_D;
        rvt_pkg::ST_NC_D: state <= rvt_pkg::ST_NC_W;
        rvt_pkg::ST_NC_W: begin
          if (div_rsp.done) begin
            nc[ax] <= div_rsp.quotient;
            if (ax_last) begin
              trav  <= lmin[rvt_pkg::TRAV_W-1:0];
              cnt   <= '0;
              state <= rvt_pkg::ST_WALK;
            end else begin
              ax    <= ax + 2'd1;
              state <= rvt_pkg::ST_VX_M1;
            end
          end
        end
        rvt_pkg::ST_WALK: begin
          o_vx   <= cur[0];
          o_vy   <= cur[1];
          o_vz   <= cur[2];
          o_len  <= len_sat;
          o_hit  <= 1'b1;
          o_last <= w_last;
          if (!w_last) begin
            trav     <= w_end;
            nc[sel]  <= nc[sel] + cs[sel];
            cur[sel] <= dx_r[sel][rvt_pkg::DX_W-1] ? cur[sel] - rvt_pkg::VOX_W'(1)
                                                   : cur[sel] + rvt_pkg::VOX_W'(1);
            cnt      <= cnt + rvt_pkg::CNT_W'(1);
          end
          state <= rvt_pkg::ST_OUT;
        end
        rvt_pkg::ST_OUT: begin
          if (seg.ready) state <= o_last ? rvt_pkg::ST_IDLE : rvt_pkg::ST_WALK;
        end
        default: state <= rvt_pkg::ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/rvt_check.sv */
// Port-level checks for the ray voxel traversal unit, bound to the top level.
`default_nettype none
module rvt_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          ray_valid,
  input wire logic                          ray_ready,
  input wire logic                          seg_valid,
  input wire logic                          seg_ready,
  input wire logic [rvt_pkg::VOX_W-1:0]     seg_vx,
  input wire logic [rvt_pkg::VOX_W-1:0]     seg_vy,
  input wire logic [rvt_pkg::VOX_W-1:0]     seg_vz,
  input wire logic [rvt_pkg::LEN_W-1:0]     seg_len,
  input wire logic                          seg_hit,
  input wire logic                          seg_last
);
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    ray_valid && ray_ready |=> !ray_ready)
    else $error("ray channel still ready after taking a request");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid &&
      $stable({seg_vx, seg_vy, seg_vz, seg_len, seg_hit, seg_last}))
    else $error("stalled result changed");

  a_miss_is_last: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_hit |-> seg_last)
    else $error("miss result not flagged last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_ready && seg_last |=> ray_ready)
    else $error("not ready for a new ray after the last result");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    ray_ready |-> !seg_valid)
    else $error("result pending while idle");
endmodule

bind ray_voxel_traversal_unit rvt_check u_rvt_check (
  .clk       (clk),
  .rst       (rst),
  .ray_valid (ray.valid),
  .ray_ready (ray.ready),
  .seg_valid (seg.valid),
  .seg_ready (seg.ready),
  .seg_vx    (seg.voxel_x),
  .seg_vy    (seg.voxel_y),
  .seg_vz    (seg.voxel_z),
  .seg_len   (seg.segment_length),
  .seg_hit   (seg.hit),
  .seg_last  (seg.last)
);
`default_nettype wire
